@@ design/dmc_pkg.sv @@
// ----------------------------------------------------------------------------
// dmc_pkg: shared types and constants for the DFS maze carver
// Command and direction codes, configuration indexes, microcode format and
// the microcode program itself.
// ----------------------------------------------------------------------------
`default_nettype none

package dmc_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int GRID_W     = 7;
    localparam int START_W    = 6;
    localparam int POS_W      = 6;
    localparam int PC_W       = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ROW = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_COL = 2'd3;

    localparam logic CMD_BEGIN = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_RIGHT = 2'd2,
        DIR_LEFT  = 2'd3
    } dir_t;

    localparam logic [1:0] LAST_TRY = 2'd3;

    typedef logic [PC_W-1:0] pc_t;

    localparam pc_t PC_IDLE     = 4'd0;
    localparam pc_t PC_DISPATCH = 4'd1;
    localparam pc_t PC_CLEAR    = 4'd2;
    localparam pc_t PC_START    = 4'd3;
    localparam pc_t PC_TOP      = 4'd4;
    localparam pc_t PC_LATCH    = 4'd5;
    localparam pc_t PC_NB       = 4'd6;
    localparam pc_t PC_TEST     = 4'd7;
    localparam pc_t PC_NEXT     = 4'd8;
    localparam pc_t PC_POP      = 4'd9;
    localparam pc_t PC_CARVE    = 4'd10;
    localparam pc_t PC_DONE     = 4'd11;

    typedef enum logic [3:0] {
        A_NONE,
        A_TAKE,
        A_CLEAR,
        A_START,
        A_RD_TOP,
        A_LATCH_TOP,
        A_NB,
        A_NEXT_DIR,
        A_POP,
        A_CARVE,
        A_DONE
    } act_t;

    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_NOT_ACC,
        C_CMD_STEP,
        C_CLR_MORE,
        C_STACK_EMPTY,
        C_NB_FREE,
        C_MORE_DIRS
    } cond_t;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        logic  wait_out;
        pc_t   target;
    } ucode_t;

    typedef struct packed {
        logic not_acc;
        logic cmd_step;
        logic clr_more;
        logic stack_empty;
        logic nb_free;
        logic more_dirs;
        logic out_busy;
    } seq_flags_t;

    function automatic ucode_t ucode_rom(input pc_t pc);
        ucode_t uc;
        case (pc)
            PC_IDLE:     uc = '{act: A_TAKE,      cond: C_NOT_ACC,     wait_out: 1'b0,
                                target: PC_IDLE};
            PC_DISPATCH: uc = '{act: A_NONE,      cond: C_CMD_STEP,    wait_out: 1'b0,
                                target: PC_TOP};
            PC_CLEAR:    uc = '{act: A_CLEAR,     cond: C_CLR_MORE,    wait_out: 1'b0,
                                target: PC_CLEAR};
            PC_START:    uc = '{act: A_START,     cond: C_ALWAYS,      wait_out: 1'b1,
                                target: PC_IDLE};
            PC_TOP:      uc = '{act: A_RD_TOP,    cond: C_STACK_EMPTY, wait_out: 1'b0,
                                target: PC_DONE};
            PC_LATCH:    uc = '{act: A_LATCH_TOP, cond: C_NEXT,        wait_out: 1'b0,
                                target: PC_IDLE};
            PC_NB:       uc = '{act: A_NB,        cond: C_NEXT,        wait_out: 1'b0,
                                target: PC_IDLE};
            PC_TEST:     uc = '{act: A_NONE,      cond: C_NB_FREE,     wait_out: 1'b0,
                                target: PC_CARVE};
            PC_NEXT:     uc = '{act: A_NEXT_DIR,  cond: C_MORE_DIRS,   wait_out: 1'b0,
                                target: PC_NB};
            PC_POP:      uc = '{act: A_POP,       cond: C_ALWAYS,      wait_out: 1'b0,
                                target: PC_TOP};
            PC_CARVE:    uc = '{act: A_CARVE,     cond: C_ALWAYS,      wait_out: 1'b1,
                                target: PC_IDLE};
            PC_DONE:     uc = '{act: A_DONE,      cond: C_ALWAYS,      wait_out: 1'b1,
                                target: PC_IDLE};
            default:     uc = '{act: A_NONE,      cond: C_ALWAYS,      wait_out: 1'b0,
                                target: PC_IDLE};
        endcase
        return uc;
    endfunction

endpackage

`default_nettype wire

@@ design/dmc_if.sv @@
// ----------------------------------------------------------------------------
// dmc_if: item channels of the DFS maze carver
// Command channel and result channel, valid/ready with payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface dmc_req_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [1:0] try_first;
    logic [1:0] try_second;
    logic [1:0] try_third;
    logic [1:0] try_fourth;

    modport source (
        output valid, cmd, try_first, try_second, try_third, try_fourth,
        input  ready
    );
    modport sink (
        input  valid, cmd, try_first, try_second, try_third, try_fourth,
        output ready
    );
endinterface

interface dmc_rsp_if;
    import dmc_pkg::*;
    logic             valid;
    logic             ready;
    logic             carved;
    logic [POS_W-1:0] from_row;
    logic [POS_W-1:0] from_col;
    logic [POS_W-1:0] to_row;
    logic [POS_W-1:0] to_col;
    logic [1:0]       carve_dir;
    logic             complete;
    logic             start_fixed;

    modport source (
        output valid, carved, from_row, from_col, to_row, to_col, carve_dir,
               complete, start_fixed,
        input  ready
    );
    modport sink (
        input  valid, carved, from_row, from_col, to_row, to_col, carve_dir,
               complete, start_fixed,
        output ready
    );
endinterface

`default_nettype wire

@@ design/dmc_ram.sv @@
// ----------------------------------------------------------------------------
// dmc_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ design/dmc_seq.sv @@
// ----------------------------------------------------------------------------
// dmc_seq: microcode sequencer
// Step counter over the control ROM with conditional jumps; holds on a
// result step while the output register is still occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module dmc_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  dmc_pkg::seq_flags_t flags,
    output dmc_pkg::ucode_t     uc
);
    import dmc_pkg::*;

    pc_t  pc_reg;
    pc_t  pc_next;
    logic taken;

    assign uc = ucode_rom(pc_reg);

    always_comb
    begin
        case (uc.cond)
            C_NEXT:        taken = 1'b0;
            C_ALWAYS:      taken = 1'b1;
            C_NOT_ACC:     taken = flags.not_acc;
            C_CMD_STEP:    taken = flags.cmd_step;
            C_CLR_MORE:    taken = flags.clr_more;
            C_STACK_EMPTY: taken = flags.stack_empty;
            C_NB_FREE:     taken = flags.nb_free;
            C_MORE_DIRS:   taken = flags.more_dirs;
            default:       taken = 1'b1;
        endcase

        if (uc.wait_out && flags.out_busy)
        begin
            pc_next = pc_reg;
        end
        else if (taken)
        begin
            pc_next = uc.target;
        end
        else
        begin
            pc_next = pc_reg + PC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

@@ design/dfs_maze_carver.sv @@
// ----------------------------------------------------------------------------
// dfs_maze_carver: recursive-backtracker maze generator, at most one carve per item
// Microcoded datapath over a visited-bit RAM and a cell-stack RAM.
// ----------------------------------------------------------------------------
// Begin item: clears the visited map, one entry per cycle, then marks and
//   pushes the start cell. Step item: reads the stack top, tries the four
//   directions in the item's order, carves at the first free neighbour or
//   pops the cell when all are rejected; an empty stack ends with completion.
// One item at a time; the next item is taken while the last result waits.
// Reset: grid 16x16, start (0,0), stack empty; visited map is cleared by begin.
`default_nettype none

module dfs_maze_carver #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [dmc_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [dmc_pkg::CFG_DATA_W-1:0]   cfg_data,
    dmc_req_if.sink                          req,
    dmc_rsp_if.source                        rsp
);
    import dmc_pkg::*;

    localparam int RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int AW     = RW + CW;
    localparam int VDEPTH = 1 << AW;
    localparam int CELLS  = MAX_ROWS * MAX_COLS;
    localparam int SAW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int SPW    = $clog2(CELLS + 1);
    localparam int DMX    = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int DW0    = $clog2(DMX + 1);
    localparam int DIM_W  = ((DW0 > GRID_W) ? DW0 : GRID_W) + 1;

    // configuration
    logic [GRID_W-1:0]  grid_rows_reg, grid_cols_reg;
    logic [START_W-1:0] start_row_reg, start_col_reg;

    // datapath
    logic                cmd_reg, cmd_next;
    dir_t                order_reg [4];
    dir_t                order_next [4];
    logic [1:0]          k_reg, k_next;
    logic [SPW-1:0]      sp_reg, sp_next;
    logic [AW-1:0]       clr_addr_reg, clr_addr_next;
    logic [RW-1:0]       cur_r_reg, cur_r_next;
    logic [CW-1:0]       cur_c_reg, cur_c_next;
    logic [RW-1:0]       nb_r_reg, nb_r_next;
    logic [CW-1:0]       nb_c_reg, nb_c_next;
    logic                nb_ok_reg, nb_ok_next;
    dir_t                dir_reg, dir_next;

    // result register
    logic                rsp_valid_reg, rsp_valid_next;
    logic                res_carved_reg, res_carved_next;
    logic [POS_W-1:0]    res_from_row_reg, res_from_row_next;
    logic [POS_W-1:0]    res_from_col_reg, res_from_col_next;
    logic [POS_W-1:0]    res_to_row_reg, res_to_row_next;
    logic [POS_W-1:0]    res_to_col_reg, res_to_col_next;
    logic [1:0]          res_dir_reg, res_dir_next;
    logic                res_complete_reg, res_complete_next;
    logic                res_fixed_reg, res_fixed_next;

    // RAM ports
    logic                vis_we, vis_re;
    logic [AW-1:0]       vis_waddr, vis_raddr;
    logic                vis_wdata, vis_rdata;
    logic                stk_we, stk_re;
    logic [SAW-1:0]      stk_waddr, stk_raddr;
    logic [AW-1:0]       stk_wdata, stk_rdata;

    ucode_t              uc;
    seq_flags_t          flags;
    logic                out_busy;
    logic                act_en;

    logic [DIM_W-1:0]    rows_eff, cols_eff;
    logic [DIM_W-1:0]    grid_rows_x, grid_cols_x;
    logic [DIM_W-1:0]    start_rx, start_cx;
    logic                start_fix;
    logic [RW-1:0]       st_r;
    logic [CW-1:0]       st_c;
    logic [DIM_W-1:0]    cur_rx, cur_cx, nb_rx, nb_cx;
    logic [DIM_W-1:0]    nbr_out_x, nbc_out_x;
    logic                nb_edge, nb_in;
    dir_t                dir_sel;
    logic [SPW-1:0]      sp_dec;

    // ---------------------------------------------------------------- grid
    always_comb
    begin
        grid_rows_x = DIM_W'(grid_rows_reg);
        grid_cols_x = DIM_W'(grid_cols_reg);
        if (grid_rows_reg == '0)
            rows_eff = DIM_W'(1);
        else if (grid_rows_x > DIM_W'(MAX_ROWS))
            rows_eff = DIM_W'(MAX_ROWS);
        else
            rows_eff = grid_rows_x;
        if (grid_cols_reg == '0)
            cols_eff = DIM_W'(1);
        else if (grid_cols_x > DIM_W'(MAX_COLS))
            cols_eff = DIM_W'(MAX_COLS);
        else
            cols_eff = grid_cols_x;

        start_rx  = DIM_W'(start_row_reg);
        start_cx  = DIM_W'(start_col_reg);
        start_fix = (start_rx >= rows_eff) || (start_cx >= cols_eff);
        st_r      = start_fix ? '0 : start_rx[RW-1:0];
        st_c      = start_fix ? '0 : start_cx[CW-1:0];
    end

    // ------------------------------------------------------------ neighbor
    always_comb
    begin
        dir_sel = order_reg[k_reg];
        cur_rx  = DIM_W'(cur_r_reg);
        cur_cx  = DIM_W'(cur_c_reg);
        nb_rx   = cur_rx;
        nb_cx   = cur_cx;
        nb_edge = 1'b0;
        case (dir_sel)
            DIR_UP:
            begin
                nb_rx   = cur_rx - DIM_W'(1);
                nb_edge = (cur_r_reg == '0);
            end
            DIR_DOWN:
            begin
                nb_rx = cur_rx + DIM_W'(1);
            end
            DIR_RIGHT:
            begin
                nb_cx = cur_cx + DIM_W'(1);
            end
            DIR_LEFT:
            begin
                nb_cx   = cur_cx - DIM_W'(1);
                nb_edge = (cur_c_reg == '0);
            end
            default:
            begin
                nb_edge = 1'b1;
            end
        endcase
        nb_in     = !nb_edge && (nb_rx < rows_eff) && (nb_cx < cols_eff);
        nbr_out_x = DIM_W'(nb_r_reg);
        nbc_out_x = DIM_W'(nb_c_reg);
        sp_dec    = sp_reg - SPW'(1);
    end

    // ------------------------------------------------------------ sequencer
    assign out_busy = rsp_valid_reg && !rsp.ready;
    assign act_en   = !(uc.wait_out && out_busy);

    always_comb
    begin
        flags.not_acc     = !(req.valid && req.ready);
        flags.cmd_step    = (cmd_reg == CMD_STEP);
        flags.clr_more    = (clr_addr_reg != '1);
        flags.stack_empty = (sp_reg == '0);
        flags.nb_free     = nb_ok_reg && !vis_rdata;
        flags.more_dirs   = (k_reg != LAST_TRY);
        flags.out_busy    = out_busy;
    end

    dmc_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .uc    (uc)
    );

    assign req.ready = (uc.act == A_TAKE);

    // ------------------------------------------------------------ datapath
    always_comb
    begin
        cmd_next      = cmd_reg;
        order_next    = order_reg;
        k_next        = k_reg;
        sp_next       = sp_reg;
        clr_addr_next = clr_addr_reg;
        cur_r_next    = cur_r_reg;
        cur_c_next    = cur_c_reg;
        nb_r_next     = nb_r_reg;
        nb_c_next     = nb_c_reg;
        nb_ok_next    = nb_ok_reg;
        dir_next      = dir_reg;

        rsp_valid_next    = rsp_valid_reg;
        res_carved_next   = res_carved_reg;
        res_from_row_next = res_from_row_reg;
        res_from_col_next = res_from_col_reg;
        res_to_row_next   = res_to_row_reg;
        res_to_col_next   = res_to_col_reg;
        res_dir_next      = res_dir_reg;
        res_complete_next = res_complete_reg;
        res_fixed_next    = res_fixed_reg;

        vis_we    = 1'b0;
        vis_waddr = clr_addr_reg;
        vis_wdata = 1'b0;
        vis_re    = 1'b0;
        vis_raddr = {nb_rx[RW-1:0], nb_cx[CW-1:0]};
        stk_we    = 1'b0;
        stk_waddr = sp_reg[SAW-1:0];
        stk_wdata = {nb_r_reg, nb_c_reg};
        stk_re    = 1'b0;
        stk_raddr = sp_dec[SAW-1:0];

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (uc.act)
            A_TAKE:
            begin
                if (req.valid)
                begin
                    cmd_next      = req.cmd;
                    order_next[0] = dir_t'(req.try_first);
                    order_next[1] = dir_t'(req.try_second);
                    order_next[2] = dir_t'(req.try_third);
                    order_next[3] = dir_t'(req.try_fourth);
                    clr_addr_next = '0;
                end
            end
            A_CLEAR:
            begin
                vis_we        = 1'b1;
                vis_waddr     = clr_addr_reg;
                vis_wdata     = 1'b0;
                clr_addr_next = clr_addr_reg + AW'(1);
            end
            A_START:
            begin
                if (act_en)
                begin
                    vis_we            = 1'b1;
                    vis_waddr         = {st_r, st_c};
                    vis_wdata         = 1'b1;
                    stk_we            = 1'b1;
                    stk_waddr         = '0;
                    stk_wdata         = {st_r, st_c};
                    sp_next           = SPW'(1);
                    rsp_valid_next    = 1'b1;
                    res_carved_next   = 1'b0;
                    res_from_row_next = start_fix ? '0 : start_row_reg;
                    res_from_col_next = start_fix ? '0 : start_col_reg;
                    res_to_row_next   = start_fix ? '0 : start_row_reg;
                    res_to_col_next   = start_fix ? '0 : start_col_reg;
                    res_dir_next      = '0;
                    res_complete_next = 1'b0;
                    res_fixed_next    = start_fix;
                end
            end
            A_RD_TOP:
            begin
                stk_re = 1'b1;
            end
            A_LATCH_TOP:
            begin
                cur_r_next = stk_rdata[AW-1:CW];
                cur_c_next = stk_rdata[CW-1:0];
                k_next     = '0;
            end
            A_NB:
            begin
                vis_re     = 1'b1;
                nb_r_next  = nb_rx[RW-1:0];
                nb_c_next  = nb_cx[CW-1:0];
                nb_ok_next = nb_in;
                dir_next   = dir_sel;
            end
            A_NEXT_DIR:
            begin
                k_next = k_reg + 2'd1;
            end
            A_POP:
            begin
                sp_next = sp_dec;
            end
            A_CARVE:
            begin
                if (act_en)
                begin
                    vis_we    = 1'b1;
                    vis_waddr = {nb_r_reg, nb_c_reg};
                    vis_wdata = 1'b1;
                    if (sp_reg != SPW'(CELLS))
                    begin
                        stk_we  = 1'b1;
                        sp_next = sp_reg + SPW'(1);
                    end
                    rsp_valid_next    = 1'b1;
                    res_carved_next   = 1'b1;
                    res_from_row_next = cur_rx[POS_W-1:0];
                    res_from_col_next = cur_cx[POS_W-1:0];
                    res_to_row_next   = nbr_out_x[POS_W-1:0];
                    res_to_col_next   = nbc_out_x[POS_W-1:0];
                    res_dir_next      = dir_reg;
                    res_complete_next = 1'b0;
                    res_fixed_next    = 1'b0;
                end
            end
            A_DONE:
            begin
                if (act_en)
                begin
                    rsp_valid_next    = 1'b1;
                    res_carved_next   = 1'b0;
                    res_from_row_next = '0;
                    res_from_col_next = '0;
                    res_to_row_next   = '0;
                    res_to_col_next   = '0;
                    res_dir_next      = '0;
                    res_complete_next = 1'b1;
                    res_fixed_next    = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------ registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= GRID_W'(16);
            grid_cols_reg <= GRID_W'(16);
            start_row_reg <= '0;
            start_col_reg <= '0;
            sp_reg        <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    CFG_GRID_ROWS: grid_rows_reg <= cfg_data[GRID_W-1:0];
                    CFG_GRID_COLS: grid_cols_reg <= cfg_data[GRID_W-1:0];
                    CFG_START_ROW: start_row_reg <= cfg_data[START_W-1:0];
                    CFG_START_COL: start_col_reg <= cfg_data[START_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            sp_reg        <= sp_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg          <= cmd_next;
        order_reg        <= order_next;
        k_reg            <= k_next;
        clr_addr_reg     <= clr_addr_next;
        cur_r_reg        <= cur_r_next;
        cur_c_reg        <= cur_c_next;
        nb_r_reg         <= nb_r_next;
        nb_c_reg         <= nb_c_next;
        nb_ok_reg        <= nb_ok_next;
        dir_reg          <= dir_next;
        res_carved_reg   <= res_carved_next;
        res_from_row_reg <= res_from_row_next;
        res_from_col_reg <= res_from_col_next;
        res_to_row_reg   <= res_to_row_next;
        res_to_col_reg   <= res_to_col_next;
        res_dir_reg      <= res_dir_next;
        res_complete_reg <= res_complete_next;
        res_fixed_reg    <= res_fixed_next;
    end

    // ------------------------------------------------------------ memories
    dmc_ram #(
        .WIDTH (1),
        .DEPTH (VDEPTH)
    ) u_visited (
        .clk   (clk),
        .we    (vis_we),
        .waddr (vis_waddr),
        .wdata (vis_wdata),
        .re    (vis_re),
        .raddr (vis_raddr),
        .rdata (vis_rdata)
    );

    dmc_ram #(
        .WIDTH (AW),
        .DEPTH (CELLS)
    ) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // ------------------------------------------------------------ outputs
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.carved      = res_carved_reg;
    assign rsp.from_row    = res_from_row_reg;
    assign rsp.from_col    = res_from_col_reg;
    assign rsp.to_row      = res_to_row_reg;
    assign rsp.to_col      = res_to_col_reg;
    assign rsp.carve_dir   = res_dir_reg;
    assign rsp.complete    = res_complete_reg;
    assign rsp.start_fixed = res_fixed_reg;

endmodule

`default_nettype wire

@@ design/dmc_checker.sv @@
// ----------------------------------------------------------------------------
// dmc_checker: port-level checks for the DFS maze carver
// Result hold, one-at-a-time intake and result field consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module dmc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic       carved,
    input logic [5:0] from_row,
    input logic [5:0] from_col,
    input logic [5:0] to_row,
    input logic [5:0] to_col,
    input logic [1:0] carve_dir,
    input logic       complete,
    input logic       start_fixed
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(carved) && $stable(from_row)
            && $stable(from_col) && $stable(to_row) && $stable(to_col)
            && $stable(carve_dir) && $stable(complete) && $stable(start_fixed))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("item taken while another is in progress");

    a_carve_flags: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && carved |-> !complete && !start_fixed)
        else $error("carve result with completion or start flag");

    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && complete |-> !carved && !start_fixed && from_row == 6'd0
            && from_col == 6'd0 && to_row == 6'd0 && to_col == 6'd0 && carve_dir == 2'd0)
        else $error("completion result with nonzero fields");

    a_begin_cell: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !carved && !complete |-> from_row == to_row && from_col == to_col
            && carve_dir == 2'd0)
        else $error("begin result with mismatched start cell");

endmodule

bind dfs_maze_carver dmc_checker u_dmc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .carved      (rsp.carved),
    .from_row    (rsp.from_row),
    .from_col    (rsp.from_col),
    .to_row      (rsp.to_row),
    .to_col      (rsp.to_col),
    .carve_dir   (rsp.carve_dir),
    .complete    (rsp.complete),
    .start_fixed (rsp.start_fixed)
);

`default_nettype wire
